@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, request codes and the sweep unit's
// command and status structures.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;

    localparam int POS_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;
    localparam int REQ_W   = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic              start;
        logic              copy;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [CELL_W-1:0] fill_value;
    } sweep_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
    } sweep_sts_t;

endpackage

@@ hdl/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// Screen cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [tcw_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [tcw_pkg::ADDR_W-1:0]  rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/tcw_sweep_unit.sv @@
// ----------------------------------------------------------------------------
// Cell sweep unit
// Address counter that fills a range of cells with one value or copies
// each cell of a range from the cell one row below it.
// ----------------------------------------------------------------------------
module tcw_sweep_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::sweep_cmd_t         cmd,
    input  logic [tcw_pkg::CELL_W-1:0]  rd_data,
    output tcw_pkg::sweep_sts_t         sts
);
    import tcw_pkg::*;

    logic              active_reg, active_next;
    logic              copy_reg, copy_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [CELL_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        active_next    = active_reg;
        copy_next      = copy_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        pend_next      = active_reg & copy_reg;
        pend_addr_next = idx_reg;
        if (cmd.start)
        begin
            active_next = 1'b1;
            copy_next   = cmd.copy;
            idx_next    = cmd.first;
            last_next   = cmd.last;
            fill_next   = cmd.fill_value;
        end
        else if (active_reg)
        begin
            if (idx_reg == last_reg)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            copy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            copy_reg   <= copy_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        fill_reg      <= fill_next;
    end

    always_comb
    begin
        sts.busy    = active_reg | pend_reg;
        sts.rd_en   = active_reg & copy_reg;
        sts.rd_addr = idx_reg + ADDR_W'(COLUMNS);
        sts.wr_en   = pend_reg | (active_reg & ~copy_reg);
        sts.wr_addr = pend_reg ? pend_addr_reg : idx_reg;
        sts.wr_data = pend_reg ? rd_data : fill_reg;
    end

    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg <= last_reg)
        else $error("sweep index beyond range end");

    a_copy_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(active_reg & copy_reg))
        else $error("copy write without preceding read");

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy)
        else $error("sweep started while busy");

endmodule

@@ hdl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// 80 x 25 console of attribute/character cells with cursor, scroll,
// clear and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block blanks all 2000 cells (attribute 0x0F, space), one
// cell a cycle, and takes no request until that sweep is done. A clear
// sweeps every cell; a put that runs past the last row copies 1920 cells
// up one row and blanks the bottom 80. The single cell store port pair
// is shared by the sweep counter and the request path. A result waiting
// in the output register does not stop the next request being taken.
module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,     // text_attribute
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // char_code, cell_address
    input  logic [1:0]                  s_axis_tuser,  // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // cursor_pos, write_address, write_value, read_data
    output logic [55:0]                 m_axis_tdata,
    output logic [1:0]                  m_axis_tuser   // cell_written, scrolled
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic              res_written_reg, res_written_next;
    logic [ADDR_W-1:0] res_waddr_reg, res_waddr_next;
    logic [CELL_W-1:0] res_wval_reg, res_wval_next;
    logic              res_scrolled_reg, res_scrolled_next;
    logic [CELL_W-1:0] res_rdata_reg, res_rdata_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [55:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    sweep_cmd_t        sweep_cmd;
    sweep_sts_t        sweep_sts;

    logic              top_wr_en;
    logic              top_rd_en;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic [REQ_W-1:0]  in_req;
    logic [CHAR_W-1:0] in_char;
    logic [POS_W-1:0]  in_addr;
    logic              in_range;
    logic              newline;
    logic              wrap;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] cursor_lin;
    logic [CELL_W-1:0] blank_cell;

    assign in_req     = s_axis_tuser;
    assign in_char    = s_axis_tdata[7:0];
    assign in_addr    = s_axis_tdata[18:8];
    assign in_range   = 32'(in_addr) < CELLS;
    assign newline    = in_char == NEWLINE_CODE;
    assign wrap       = newline || (32'(col_reg) == COLUMNS - 1);
    assign put_addr   = row_base_reg + ADDR_W'(col_reg);
    assign cursor_lin = row_base_reg + ADDR_W'(col_reg);
    assign blank_cell = {attr_reg, BLANK_CODE};

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_comb
    begin
        state_next        = state_reg;
        attr_next         = cfg_we ? cfg_wdata : attr_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        row_base_next     = row_base_reg;
        res_written_next  = res_written_reg;
        res_waddr_next    = res_waddr_reg;
        res_wval_next     = res_wval_reg;
        res_scrolled_next = res_scrolled_reg;
        res_rdata_next    = res_rdata_reg;
        rd_ok_next        = rd_ok_reg;
        m_valid_next      = m_valid_reg & ~m_axis_tready;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;
        sweep_cmd         = '0;
        top_wr_en         = 1'b0;
        top_rd_en         = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                sweep_cmd.start      = 1'b1;
                sweep_cmd.first      = '0;
                sweep_cmd.last       = ADDR_W'(CELLS - 1);
                sweep_cmd.fill_value = {ATTR_RESET, BLANK_CODE};
                state_next           = ST_INIT_WAIT;
            end
            ST_INIT_WAIT:
            begin
                if (!sweep_sts.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_written_next  = 1'b0;
                    res_waddr_next    = '0;
                    res_wval_next     = '0;
                    res_scrolled_next = 1'b0;
                    res_rdata_next    = '0;
                    state_next        = ST_RESULT;
                    case (in_req)
                        REQ_PUT:
                        begin
                            if (!newline)
                            begin
                                top_wr_en        = 1'b1;
                                res_written_next = 1'b1;
                                res_waddr_next   = put_addr;
                                res_wval_next    = {attr_reg, in_char};
                            end
                            col_next = wrap ? '0 : col_reg + COL_W'(1);
                            if (wrap)
                            begin
                                if (32'(row_reg) == ROWS - 1)
                                begin
                                    res_scrolled_next = 1'b1;
                                    sweep_cmd.start   = 1'b1;
                                    sweep_cmd.copy    = 1'b1;
                                    sweep_cmd.first   = '0;
                                    sweep_cmd.last    = ADDR_W'(CELLS - COLUMNS - 1);
                                    state_next        = ST_COPY;
                                end
                                else
                                begin
                                    row_next      = row_reg + ROW_W'(1);
                                    row_base_next = row_base_reg + ADDR_W'(COLUMNS);
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            sweep_cmd.start      = 1'b1;
                            sweep_cmd.first      = '0;
                            sweep_cmd.last       = ADDR_W'(CELLS - 1);
                            sweep_cmd.fill_value = blank_cell;
                            col_next             = '0;
                            row_next             = '0;
                            row_base_next        = '0;
                            state_next           = ST_CLEAR;
                        end
                        REQ_READ:
                        begin
                            top_rd_en  = in_range;
                            rd_ok_next = in_range;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_rdata_next = rd_ok_reg ? ram_rd_data : '0;
                state_next     = ST_RESULT;
            end
            ST_COPY:
            begin
                if (!sweep_cmd.start && !sweep_sts.busy)
                begin
                    sweep_cmd.start      = 1'b1;
                    sweep_cmd.first      = ADDR_W'(CELLS - COLUMNS);
                    sweep_cmd.last       = ADDR_W'(CELLS - 1);
                    sweep_cmd.fill_value = blank_cell;
                    state_next           = ST_BLANK;
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                if (!sweep_sts.busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_rdata_reg, res_wval_reg,
                                    POS_W'(res_waddr_reg), POS_W'(cursor_lin)};
                    m_user_next  = {res_scrolled_reg, res_written_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            attr_reg         <= ATTR_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            row_base_reg     <= '0;
            res_written_reg  <= 1'b0;
            res_waddr_reg    <= '0;
            res_wval_reg     <= '0;
            res_scrolled_reg <= 1'b0;
            res_rdata_reg    <= '0;
            rd_ok_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            m_user_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            attr_reg         <= attr_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            row_base_reg     <= row_base_next;
            res_written_reg  <= res_written_next;
            res_waddr_reg    <= res_waddr_next;
            res_wval_reg     <= res_wval_next;
            res_scrolled_reg <= res_scrolled_next;
            res_rdata_reg    <= res_rdata_next;
            rd_ok_reg        <= rd_ok_next;
            m_valid_reg      <= m_valid_next;
            m_data_reg       <= m_data_next;
            m_user_reg       <= m_user_next;
        end
    end

    always_comb
    begin
        ram_wr_en   = sweep_sts.wr_en | top_wr_en;
        ram_wr_addr = sweep_sts.wr_en ? sweep_sts.wr_addr : put_addr;
        ram_wr_data = sweep_sts.wr_en ? sweep_sts.wr_data : {attr_reg, in_char};
        ram_rd_en   = sweep_sts.rd_en | top_rd_en;
        ram_rd_addr = sweep_sts.rd_en ? sweep_sts.rd_addr : ADDR_W'(in_addr);
    end

    tcw_sweep_unit u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (sweep_cmd),
        .rd_data (ram_rd_data),
        .sts     (sweep_sts)
    );

    tcw_cell_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    a_ready_only_when_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sweep_sts.busy)
        else $error("request taken while sweep running");

    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor outside screen");

    a_row_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_base_reg) == 32'(row_reg) * COLUMNS)
        else $error("row base out of step with row");

endmodule
